[hdl/swfp_pkg.sv]
// ----------------------------------------------------------------------------
// swfp_pkg
// Shared types and constants for the sync word frame parser.
// ----------------------------------------------------------------------------
package swfp_pkg;

    localparam int PAYLOAD_WORDS_DEFAULT = 3;

    localparam int WORD_W    = 16;
    localparam int SEQ_W     = 8;
    localparam int PHASE_W   = 3;
    localparam int COUNT_W   = 32;
    localparam int PAT_WORDS = 3;
    localparam int PAT_W     = PAT_WORDS * WORD_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] SYNC_RESET   = 16'hA5A5;
    localparam logic [SEQ_W-1:0]  PREFIX_RESET = 8'h5A;

    localparam logic [PHASE_W-1:0] PHASE_HUNT  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_SEQ   = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_DATA0 = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_PATTERN = 1'b0,
        CFG_SEQ_PREFIX   = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [WORD_W-1:0] rx_word;
        logic              link_error;
    } rx_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] sync_pattern;
        logic [SEQ_W-1:0]  sequence_prefix;
    } cfg_t;

endpackage

[hdl/sync_word_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// sync_word_frame_parser_unit
// Sync word deframer: finds sync / sequence / payload frames in a word stream.
// ----------------------------------------------------------------------------
// Takes one 16-bit link word per item and returns one result per item. An
// item can be accepted every clock cycle while out_ready stays high; each item
// passes an input register and is then processed into the parser state,
// which is also the result register, so a result appears once the item has
// passed both registers. in_ready follows out_ready through the input
// register's take signal. Configuration writes are registered and should be
// made while no item is in flight.
module sync_word_frame_parser_unit #(
    parameter int PAYLOAD_WORDS = swfp_pkg::PAYLOAD_WORDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [swfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swfp_pkg::WORD_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [swfp_pkg::WORD_W-1:0]        rx_word,
    input  logic                               link_error,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               frame_done,
    output logic [swfp_pkg::PAT_W-1:0]         channel_pattern,
    output logic [swfp_pkg::SEQ_W-1:0]         last_sequence,
    output logic [swfp_pkg::COUNT_W-1:0]       good_frames,
    output logic [swfp_pkg::COUNT_W-1:0]       bad_frames,
    output logic [swfp_pkg::COUNT_W-1:0]       resync_count,
    output logic [swfp_pkg::PHASE_W-1:0]       parser_phase
);
    import swfp_pkg::*;

    rx_item_t in_item;
    rx_item_t item;
    logic     item_valid;
    logic     take;
    cfg_t     cfg;

    assign in_item.rx_word    = rx_word;
    assign in_item.link_error = link_error;

    swfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swfp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    swfp_core #(
        .PAYLOAD_WORDS (PAYLOAD_WORDS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .item_valid      (item_valid),
        .item            (item),
        .take            (take),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .frame_done      (frame_done),
        .channel_pattern (channel_pattern),
        .last_sequence   (last_sequence),
        .good_frames     (good_frames),
        .bad_frames      (bad_frames),
        .resync_count    (resync_count),
        .parser_phase    (parser_phase)
    );

endmodule

[hdl/swfp_in_stage.sv]
// ----------------------------------------------------------------------------
// swfp_in_stage
// Input register: holds one received item until the core takes it.
// ----------------------------------------------------------------------------
module swfp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swfp_pkg::rx_item_t in_item,
    input  logic              take,
    output logic              item_valid,
    output swfp_pkg::rx_item_t item
);
    import swfp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/swfp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// swfp_cfg_regs
// Configuration registers: sync pattern and sequence prefix.
// ----------------------------------------------------------------------------
module swfp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swfp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swfp_pkg::WORD_W-1:0]         cfg_data,
    output swfp_pkg::cfg_t                      cfg
);
    import swfp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_SYNC_PATTERN: cfg_next.sync_pattern    = cfg_data;
                CFG_SEQ_PREFIX:   cfg_next.sequence_prefix = cfg_data[SEQ_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_pattern    <= SYNC_RESET;
            cfg_reg.sequence_prefix <= PREFIX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/swfp_core.sv]
// ----------------------------------------------------------------------------
// swfp_core
// Frame phase tracking, payload capture, publishing and counters. The state
// registers double as the result register.
// ----------------------------------------------------------------------------
module swfp_core #(
    parameter int PAYLOAD_WORDS = swfp_pkg::PAYLOAD_WORDS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  swfp_pkg::cfg_t                     cfg,
    input  logic                               item_valid,
    input  swfp_pkg::rx_item_t                 item,
    output logic                               take,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               frame_done,
    output logic [swfp_pkg::PAT_W-1:0]         channel_pattern,
    output logic [swfp_pkg::SEQ_W-1:0]         last_sequence,
    output logic [swfp_pkg::COUNT_W-1:0]       good_frames,
    output logic [swfp_pkg::COUNT_W-1:0]       bad_frames,
    output logic [swfp_pkg::COUNT_W-1:0]       resync_count,
    output logic [swfp_pkg::PHASE_W-1:0]       parser_phase
);
    import swfp_pkg::*;

    localparam int SLOT_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;
    localparam logic [PHASE_W-1:0] PHASE_LAST =
        PHASE_W'(int'(PHASE_DATA0) + PAYLOAD_WORDS - 1);

    logic                out_valid_reg, out_valid_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [SEQ_W-1:0]    pend_seq_reg, pend_seq_next;
    logic [WORD_W-1:0]   hold_reg [PAYLOAD_WORDS];
    logic [PAT_W-1:0]    pattern_reg, pattern_next;
    logic [SEQ_W-1:0]    pub_seq_reg, pub_seq_next;
    logic [COUNT_W-1:0]  good_reg, good_next;
    logic [COUNT_W-1:0]  bad_reg, bad_next;
    logic [COUNT_W-1:0]  resync_reg, resync_next;
    logic                done_reg, done_next;

    logic                is_sync;
    logic                prefix_ok;
    logic                in_data;
    logic [SLOT_W-1:0]   slot;
    logic                hold_we;
    logic [PAT_W-1:0]    pattern_built;

    assign take = item_valid && (!out_valid_reg || out_ready);

    assign is_sync   = (item.rx_word == cfg.sync_pattern);
    assign prefix_ok = (item.rx_word[WORD_W-1:SEQ_W] == cfg.sequence_prefix);
    assign in_data   = (phase_reg >= PHASE_DATA0) && (phase_reg <= PHASE_LAST);
    assign slot      = SLOT_W'(phase_reg - PHASE_DATA0);

    // last payload word comes straight from the current item
    always_comb
    begin
        pattern_built = '0;
        for (int i = 0; i < PAT_WORDS; i++)
        begin
            if (i < PAYLOAD_WORDS)
            begin
                if (i == PAYLOAD_WORDS - 1)
                begin
                    pattern_built[WORD_W*i +: WORD_W] = item.rx_word;
                end
                else
                begin
                    pattern_built[WORD_W*i +: WORD_W] = hold_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        pend_seq_next = pend_seq_reg;
        pattern_next  = pattern_reg;
        pub_seq_next  = pub_seq_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        resync_next   = resync_reg;
        done_next     = 1'b0;
        hold_we       = 1'b0;

        if (item.link_error)
        begin
            bad_next   = bad_reg + 1'b1;
            phase_next = PHASE_HUNT;
        end
        else if (phase_reg == PHASE_HUNT)
        begin
            if (is_sync)
            begin
                phase_next = PHASE_SEQ;
            end
        end
        else if (phase_reg == PHASE_SEQ)
        begin
            if (prefix_ok)
            begin
                pend_seq_next = item.rx_word[SEQ_W-1:0];
                phase_next    = PHASE_DATA0;
            end
            else if (is_sync)
            begin
                resync_next = resync_reg + 1'b1;
            end
            else
            begin
                bad_next   = bad_reg + 1'b1;
                phase_next = PHASE_HUNT;
            end
        end
        else if (in_data)
        begin
            if (is_sync)
            begin
                resync_next = resync_reg + 1'b1;
                phase_next  = PHASE_SEQ;
            end
            else
            begin
                hold_we = 1'b1;
                if (phase_reg == PHASE_LAST)
                begin
                    pattern_next = pattern_built;
                    pub_seq_next = pend_seq_reg;
                    good_next    = good_reg + 1'b1;
                    done_next    = 1'b1;
                    phase_next   = PHASE_HUNT;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
        else
        begin
            phase_next = PHASE_HUNT;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= PHASE_HUNT;
            pend_seq_reg  <= '0;
            pattern_reg   <= '0;
            pub_seq_reg   <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            resync_reg    <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < PAYLOAD_WORDS; i++)
            begin
                hold_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                pend_seq_reg <= pend_seq_next;
                pattern_reg  <= pattern_next;
                pub_seq_reg  <= pub_seq_next;
                good_reg     <= good_next;
                bad_reg      <= bad_next;
                resync_reg   <= resync_next;
                done_reg     <= done_next;
                if (hold_we)
                begin
                    hold_reg[slot] <= item.rx_word;
                end
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_done      = done_reg;
    assign channel_pattern = pattern_reg;
    assign last_sequence   = pub_seq_reg;
    assign good_frames     = good_reg;
    assign bad_frames      = bad_reg;
    assign resync_count    = resync_reg;
    assign parser_phase    = phase_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync word frame parser.
// ----------------------------------------------------------------------------
// Link words are fed from a queue through a valid/ready driver. An in-bench
// parser model computes the status that each accepted word should produce.
// A monitor compares every returned status against the oldest prediction.
// The run steps through several sync/prefix register settings and several
// handshake idling mixes. Directed frames come first, then random frames
// with resyncs, bad sequence words and link errors mixed in.
// ----------------------------------------------------------------------------
module tb_top;
    import swfp_pkg::*;

    localparam int PAYLOAD_WORDS  = PAYLOAD_WORDS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic               done;
        logic [PAT_W-1:0]   pattern;
        logic [SEQ_W-1:0]   sequence_num;
        logic [COUNT_W-1:0] good;
        logic [COUNT_W-1:0] bad;
        logic [COUNT_W-1:0] resync;
        logic [PHASE_W-1:0] phase;
    } parser_status_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_PATTERN;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [WORD_W-1:0]    rx_word = '0;
    logic                 link_error = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 frame_done;
    logic [PAT_W-1:0]     channel_pattern;
    logic [SEQ_W-1:0]     last_sequence;
    logic [COUNT_W-1:0]   good_frames;
    logic [COUNT_W-1:0]   bad_frames;
    logic [COUNT_W-1:0]   resync_count;
    logic [PHASE_W-1:0]   parser_phase;

    // parser model state
    logic [WORD_W-1:0]    cur_sync = SYNC_RESET;
    logic [SEQ_W-1:0]     cur_prefix = PREFIX_RESET;
    logic [PHASE_W-1:0]   mdl_phase = PHASE_HUNT;
    logic [SEQ_W-1:0]     mdl_pending_seq = '0;
    logic [WORD_W-1:0]    mdl_hold [PAYLOAD_WORDS];
    logic [PAT_W-1:0]     mdl_pattern = '0;
    logic [SEQ_W-1:0]     mdl_pub_seq = '0;
    logic [COUNT_W-1:0]   mdl_good = '0;
    logic [COUNT_W-1:0]   mdl_bad = '0;
    logic [COUNT_W-1:0]   mdl_resync = '0;

    rx_item_t       word_q [$];
    parser_status_t status_q [$];
    rx_item_t       drive_item;
    parser_status_t got_status;
    parser_status_t want_status;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int fail_count = 0;
    int items_taken = 0;
    int results_checked = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    sync_word_frame_parser_unit #(
        .PAYLOAD_WORDS(PAYLOAD_WORDS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_word(rx_word),
        .link_error(link_error),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .frame_done(frame_done),
        .channel_pattern(channel_pattern),
        .last_sequence(last_sequence),
        .good_frames(good_frames),
        .bad_frames(bad_frames),
        .resync_count(resync_count),
        .parser_phase(parser_phase)
    );

    always #1 clk = ~clk;

    initial
    begin
        for (int i = 0; i < PAYLOAD_WORDS; i++)
        begin
            mdl_hold[i] = '0;
        end
    end

    function automatic parser_status_t advance_parser(rx_item_t it);
        parser_status_t res;
        logic           is_sync;
        int             slot;
        res = '0;
        is_sync = (it.rx_word == cur_sync);
        if (it.link_error)
        begin
            mdl_bad = mdl_bad + 1'b1;
            mdl_phase = PHASE_HUNT;
        end
        else if (mdl_phase == PHASE_HUNT)
        begin
            if (is_sync)
            begin
                mdl_phase = PHASE_SEQ;
            end
        end
        else if (mdl_phase == PHASE_SEQ)
        begin
            if (it.rx_word[WORD_W-1:SEQ_W] == cur_prefix)
            begin
                mdl_pending_seq = it.rx_word[SEQ_W-1:0];
                mdl_phase = PHASE_DATA0;
            end
            else if (is_sync)
            begin
                mdl_resync = mdl_resync + 1'b1;
            end
            else
            begin
                mdl_bad = mdl_bad + 1'b1;
                mdl_phase = PHASE_HUNT;
            end
        end
        else if (mdl_phase >= PHASE_DATA0
                 && int'(mdl_phase) < int'(PHASE_DATA0) + PAYLOAD_WORDS)
        begin
            slot = int'(mdl_phase) - int'(PHASE_DATA0);
            if (is_sync)
            begin
                mdl_resync = mdl_resync + 1'b1;
                mdl_phase = PHASE_SEQ;
            end
            else
            begin
                mdl_hold[slot] = it.rx_word;
                if (slot == PAYLOAD_WORDS - 1)
                begin
                    mdl_pattern = '0;
                    for (int i = 0; i < PAYLOAD_WORDS && i < PAT_WORDS; i++)
                    begin
                        mdl_pattern[WORD_W*i +: WORD_W] = mdl_hold[i];
                    end
                    mdl_pub_seq = mdl_pending_seq;
                    mdl_good = mdl_good + 1'b1;
                    res.done = 1'b1;
                    mdl_phase = PHASE_HUNT;
                end
                else
                begin
                    mdl_phase = mdl_phase + 1'b1;
                end
            end
        end
        else
        begin
            mdl_phase = PHASE_HUNT;
        end
        res.pattern = mdl_pattern;
        res.sequence_num = mdl_pub_seq;
        res.good = mdl_good;
        res.bad = mdl_bad;
        res.resync = mdl_resync;
        res.phase = mdl_phase;
        return res;
    endfunction

    function automatic void push_word(logic [WORD_W-1:0] w, logic err);
        rx_item_t it;
        it.rx_word = w;
        it.link_error = err;
        word_q.push_back(it);
    endfunction

    // one frame, mostly well formed; returns the number of words queued
    function automatic int queue_frame();
        int n;
        int r;
        n = 0;
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 3))
            begin
                push_word(16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
                n++;
            end
        end
        push_word(cur_sync, 1'b0);
        n++;
        if ($urandom_range(0, 19) == 0)
        begin
            push_word(cur_sync, 1'b0);
            n++;
        end
        if ($urandom_range(0, 14) == 0)
        begin
            push_word({~cur_prefix, 8'($urandom_range(0, 255))}, 1'b0);
            return n + 1;
        end
        push_word({cur_prefix, 8'($urandom_range(0, 255))}, 1'b0);
        n++;
        for (int i = 0; i < PAYLOAD_WORDS; i++)
        begin
            r = $urandom_range(0, 49);
            if (r == 0)
            begin
                push_word(16'($urandom_range(0, 65535)), 1'b1);
                return n + 1;
            end
            if (r == 1)
            begin
                push_word(cur_sync, 1'b0);
                push_word({cur_prefix, 8'($urandom_range(0, 255))}, 1'b0);
                n += 2;
            end
            if (r == 2)
            begin
                push_word('1, 1'b0);
            end
            else if (r == 3)
            begin
                push_word('0, 1'b0);
            end
            else
            begin
                push_word(16'($urandom_range(0, 65535)), 1'b0);
            end
            n++;
        end
        return n;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_item.rx_word = rx_word;
            drive_item.link_error = link_error;
            status_q.push_back(advance_parser(drive_item));
            items_taken++;
        end
        if (!in_valid || in_ready)
        begin
            if (rst_n && word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                drive_item = word_q.pop_front();
                in_valid <= 1'b1;
                rx_word <= drive_item.rx_word;
                link_error <= drive_item.link_error;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_status = {frame_done, channel_pattern, last_sequence, good_frames,
                          bad_frames, resync_count, parser_phase};
            if (status_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("unexpected result, none pending: done=%0d phase=%0d",
                             frame_done, parser_phase);
                end
            end
            else
            begin
                want_status = status_q.pop_front();
                results_checked++;
                if (got_status !== want_status)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("result %0d: exp done=%0d pat=%h seq=%h good=%0d bad=%0d rs=%0d ph=%0d",
                                 results_checked, want_status.done, want_status.pattern,
                                 want_status.sequence_num, want_status.good, want_status.bad,
                                 want_status.resync, want_status.phase);
                        $display("           got done=%0d pat=%h seq=%h good=%0d bad=%0d rs=%0d ph=%0d",
                                 got_status.done, got_status.pattern, got_status.sequence_num,
                                 got_status.good, got_status.bad, got_status.resync,
                                 got_status.phase);
                    end
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic wait_drained();
        @(negedge clk);
        while (word_q.size() != 0 || in_valid || status_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [WORD_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC_PATTERN)
        begin
            cur_sync = value;
        end
        else
        begin
            cur_prefix = value[SEQ_W-1:0];
        end
    endtask

    task automatic set_config(logic [WORD_W-1:0] sync_value, logic [WORD_W-1:0] prefix_value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_SYNC_PATTERN, sync_value);
        write_reg(CFG_SEQ_PREFIX, prefix_value);
        settings_used++;
        @(negedge clk);
    endtask

    // pause: sender holds off until the block has drained between chunks
    task automatic run_random(int count, int idle_pct, int stall_pct, bit pause);
        int queued;
        int chunk_end;
        queued = 0;
        @(negedge clk);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (queued < count)
        begin
            chunk_end = pause ? queued + $urandom_range(20, 80) : count;
            while (queued < chunk_end && queued < count)
            begin
                queued += queue_frame();
            end
            if (pause)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        settings_used = 1;

        // reset settings: hunt, resyncs, bad sequence, link errors, extremes
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b1);
        push_word(SYNC_RESET, 1'b0);
        push_word(SYNC_RESET, 1'b0);
        push_word({PREFIX_RESET, 8'h00}, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(SYNC_RESET, 1'b0);
        push_word({PREFIX_RESET, 8'hFF}, 1'b0);
        push_word(16'h0000, 1'b0);
        push_word(16'hFFFF, 1'b0);
        push_word(16'h8001, 1'b0);
        push_word(SYNC_RESET, 1'b0);
        push_word(16'h1234, 1'b0);
        push_word(SYNC_RESET, 1'b0);
        push_word(SYNC_RESET, 1'b1);
        push_word(SYNC_RESET, 1'b0);
        push_word({PREFIX_RESET, 8'h7E}, 1'b0);
        push_word(16'h1111, 1'b0);
        push_word(16'h5A5A, 1'b1);
        push_word(SYNC_RESET, 1'b0);
        push_word({PREFIX_RESET, 8'h81}, 1'b0);
        push_word(16'h00FF, 1'b0);
        push_word(16'hFF00, 1'b0);
        push_word(16'hA5A4, 1'b0);

        // sync word whose top byte is the prefix: taken as the sequence word
        set_config(16'h5A5A, {8'($urandom_range(0, 255)), 8'h5A});
        push_word(16'h5A5A, 1'b0);
        push_word(16'h5A5A, 1'b0);
        push_word(16'h5A5A, 1'b0);
        push_word(16'h5A5A, 1'b0);
        push_word(16'hC3C3, 1'b0);
        push_word(16'h3C3C, 1'b0);
        push_word(16'h5A5B, 1'b0);
        run_random(400, 0, 0, 1'b0);

        set_config(16'h0000, {8'($urandom_range(0, 255)), 8'h00});
        run_random(400, 73, 0, 1'b0);

        set_config(16'hFFFF, {8'($urandom_range(0, 255)), 8'hFF});
        run_random(400, 0, 73, 1'b0);

        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        run_random(400, 34, 34, 1'b0);

        set_config(SYNC_RESET, {8'($urandom_range(0, 255)), PREFIX_RESET});
        run_random(400, 0, 34, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (status_q.size() != 0)
        begin
            $display("%0d results never arrived", status_q.size());
        end
        $display("covered %0d words under %0d register settings, %0d results checked",
                 items_taken, settings_used, results_checked);
        $display("model saw %0d good frames, %0d bad frames, %0d resyncs; %0d mismatches",
                 mdl_good, mdl_bad, mdl_resync, fail_count);
        if (fail_count == 0 && status_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
